>>> rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timer queue
// Command and result encodings, transaction payloads and default sizes.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int unsigned PoolDepthDef    = 64;
  localparam int unsigned RequestCountDef = 256;
  localparam int unsigned TimeBitsDef     = 48;

  localparam int unsigned NowW   = 48;
  localparam int unsigned TmoW   = 32;
  localparam int unsigned ReqW   = 8;
  localparam int unsigned WaitW  = 31;

  localparam logic [WaitW-1:0] WaitMax = '1;

  typedef enum logic [1:0] {
    M_ADD    = 2'd0,
    M_DELETE = 2'd1,
    M_EXPIRE = 2'd2,
    M_FIND   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    K_ADDED   = 3'd0,
    K_FULL    = 3'd1,
    K_DELETED = 3'd2,
    K_EXPIRED = 3'd3,
    K_NONE    = 3'd4,
    K_WAIT    = 3'd5,
    K_NOTIMER = 3'd6,
    K_NODEL   = 3'd7
  } kind_e;

  typedef struct packed {
    mode_e            mode;
    logic [NowW-1:0]  now_ms;
    logic [TmoW-1:0]  timeout_ms;
    logic [ReqW-1:0]  request_id;
    logic             has_handler;
  } in_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [ReqW-1:0]  request_id_out;
    logic             run_handler;
    logic [WaitW-1:0] wait_ms;
    logic             last;
  } out_item_t;

  function automatic out_item_t mk_res(kind_e k, logic [ReqW-1:0] r, logic h,
                                       logic [WaitW-1:0] w, logic l);
    out_item_t o;
    o.kind           = k;
    o.request_id_out = r;
    o.run_handler    = h;
    o.wait_ms        = w;
    o.last           = l;
    return o;
  endfunction

endpackage

>>> rtl/dtq_if.sv
// ----------------------------------------------------------------------------
// dtq_if: command and result channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface dtq_in_if;
  import dtq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dtq_out_if;
  import dtq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/deadline_timer_queue.sv
// Add: a rejected add goes straight to its result, else the new key climbs level by
//   level. Delete reads the link, then marks the slot; find and expire read the top.
// Each minimum popped, deleted or expired, is then sifted down level by level; an
//   expired result is held for one pop so that "last" can be set. Output stalls pause work.
// Throughput: one command at a time; the next is taken once the previous result sits
//   in the output register. Reset: heap empty, all slots free, no request linked.
// ----------------------------------------------------------------------------
// deadline_timer_queue: binary min-heap timer queue with lazy deletion
// Heap entries {slot, deadline} live in one RAM; per-slot node data and the
// request-to-slot links live in small RAMs. A sequencer walks the heap.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
  parameter int unsigned POOL_DEPTH    = dtq_pkg::PoolDepthDef,
  parameter int unsigned REQUEST_COUNT = dtq_pkg::RequestCountDef,
  parameter int unsigned TIME_BITS     = dtq_pkg::TimeBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtq_in_if.sink    in_i,
  dtq_out_if.source out_o
);
  import dtq_pkg::*;

  localparam int unsigned SW  = $clog2(POOL_DEPTH);      // slot / heap address
  localparam int unsigned CW  = $clog2(POOL_DEPTH + 1);  // heap count
  localparam int unsigned PW  = CW + 1;                  // 1-based position, 2p
  localparam int unsigned RIW = $clog2(REQUEST_COUNT);   // request table index
  localparam int unsigned TB  = TIME_BITS;

  typedef struct packed {
    logic [SW-1:0] slot;
    logic [TB-1:0] dl;
  } hent_t;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic            hnd;
  } node_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD, S_UP_RD, S_UP_CMP, S_DEL, S_DEL_WR, S_TOP, S_TOP_RD,
    S_NODE_CHK, S_POP_RS, S_POP_LINK, S_POP_LAST, S_DN, S_DN_RL, S_DN_CMP,
    S_FIN, S_EMIT
  } state_e;

  // ---- registers ----
  state_e          state_q, state_d;
  in_item_t        cmd_q, cmd_d;
  logic [RIW-1:0]  ri_q, ri_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [PW-1:0]   pos_q, pos_d;
  hent_t           key_q, key_d;     // entry being sifted
  hent_t           top_q, top_d;     // current heap minimum
  hent_t           left_q, left_d;
  logic [POOL_DEPTH-1:0] free_q, free_d;
  logic            has_timer_q [REQUEST_COUNT];
  out_item_t       res_q, res_d;     // single result waiting for the output register
  out_item_t       pend_q, pend_d;   // expired result held until "last" is known
  logic            pend_vld_q, pend_vld_d;
  out_item_t       out_q, out_d;
  logic            out_vld_q, out_vld_d;

  // ---- memories ----
  hent_t           heap_mem [POOL_DEPTH];
  node_t           node_mem [POOL_DEPTH];
  logic            del_mem  [POOL_DEPTH];
  logic [SW-1:0]   rs_mem   [REQUEST_COUNT];

  hent_t           heap_rd_q;
  node_t           node_rd_q;
  logic            del_rd_q;
  logic [SW-1:0]   rs_rd_q;

  logic            heap_we, heap_re, node_we, node_re, del_we, rs_we, rs_re;
  logic [SW-1:0]   heap_wa, heap_ra, node_wa, node_ra, del_wa;
  logic [RIW-1:0]  rs_wa, rs_ra;
  hent_t           heap_wd;
  node_t           node_wd;
  logic            del_wd;
  logic [SW-1:0]   rs_wd;
  logic            ht_set, ht_clr;
  logic [RIW-1:0]  ht_idx;

  // ---- derived values ----
  logic            out_free;
  logic [63:0]     now64, tmo64;
  logic [TB-1:0]   now_t, tmo_t, dl_new, diff;
  logic [TB:0]     dl_sum;
  logic [WaitW-1:0] wait_v;
  logic [SW-1:0]   first_free;
  logic [31:0]     in_req_ext, node_req_ext;
  logic            in_req_ok, node_req_ok;
  logic [RIW-1:0]  node_ri;
  logic [PW-1:0]   two_p;
  logic            use_right;
  hent_t           child;
  logic [PW-1:0]   child_pos;

  assign out_free = !out_vld_q || out_o.ready;

  assign now64  = 64'(cmd_q.now_ms);
  assign tmo64  = 64'(cmd_q.timeout_ms);
  assign now_t  = now64[TB-1:0];
  assign tmo_t  = tmo64[TB-1:0];
  assign dl_sum = {1'b0, now_t} + {1'b0, tmo_t};
  assign dl_new = dl_sum[TB] ? '1 : dl_sum[TB-1:0];   // saturate on overflow

  // time to the earliest deadline, clamped at zero and saturated
  assign diff   = top_q.dl - now_t;
  assign wait_v = (top_q.dl <= now_t) ? '0 :
                  (diff > TB'(WaitMax)) ? WaitMax : diff[WaitW-1:0];

  assign in_req_ext   = 32'(cmd_q.request_id);
  assign in_req_ok    = in_req_ext < REQUEST_COUNT;
  assign node_req_ext = 32'(node_rd_q.req);
  assign node_req_ok  = node_req_ext < REQUEST_COUNT;
  assign node_ri      = node_req_ext[RIW-1:0];

  assign two_p     = {pos_q[PW-2:0], 1'b0};
  assign use_right = (two_p < PW'(cnt_q)) && (heap_rd_q.dl < left_q.dl);
  assign child     = use_right ? heap_rd_q : left_q;
  assign child_pos = use_right ? two_p + PW'(1) : two_p;

  // lowest free pool slot
  always_comb begin
    first_free = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (free_q[i]) first_free = SW'(i);
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  // ---- sequencer ----
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    ri_d       = ri_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    key_d      = key_q;
    top_d      = top_q;
    left_d     = left_q;
    free_d     = free_q;
    res_d      = res_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_re = 1'b0; heap_ra = '0;
    node_we = 1'b0; node_wa = '0; node_wd = '0; node_re = 1'b0; node_ra = '0;
    del_we  = 1'b0; del_wa  = '0; del_wd  = 1'b0;
    rs_we   = 1'b0; rs_wa   = '0; rs_wd   = '0; rs_re   = 1'b0; rs_ra   = '0;
    ht_set  = 1'b0; ht_clr  = 1'b0; ht_idx = ri_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d = in_i.payload;
          ri_d  = RIW'(32'(in_i.payload.request_id));
          case (in_i.payload.mode)
            M_ADD:    state_d = S_ADD;
            M_DELETE: state_d = S_DEL;
            default:  state_d = S_TOP;
          endcase
        end
      end

      S_ADD: begin
        if (!in_req_ok || free_q == '0 || 32'(cnt_q) >= POOL_DEPTH) begin
          res_d   = mk_res(K_FULL, cmd_q.request_id, 1'b0, '0, 1'b1);
          state_d = S_EMIT;
        end else begin
          node_we = 1'b1; node_wa = first_free;
          node_wd = '{req: cmd_q.request_id, hnd: cmd_q.has_handler};
          del_we  = 1'b1; del_wa = first_free; del_wd = 1'b0;
          rs_we   = 1'b1; rs_wa = ri_q; rs_wd = first_free;
          ht_set  = 1'b1;
          free_d[first_free] = 1'b0;
          cnt_d   = cnt_q + CW'(1);
          pos_d   = PW'(cnt_q) + PW'(1);
          key_d   = '{slot: first_free, dl: dl_new};
          state_d = S_UP_RD;
        end
      end

      // sift-up with a hole: parents move down until the new key fits
      S_UP_RD: begin
        if (pos_q == PW'(1)) begin
          heap_we = 1'b1; heap_wa = '0; heap_wd = key_q;
          res_d   = mk_res(K_ADDED, cmd_q.request_id, 1'b0, '0, 1'b1);
          state_d = S_EMIT;
        end else begin
          heap_re = 1'b1; heap_ra = SW'((pos_q >> 1) - PW'(1));
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        heap_we = 1'b1; heap_wa = SW'(pos_q - PW'(1));
        if (key_q.dl < heap_rd_q.dl) begin
          heap_wd = heap_rd_q;
          pos_d   = pos_q >> 1;
          state_d = S_UP_RD;
        end else begin
          heap_wd = key_q;
          res_d   = mk_res(K_ADDED, cmd_q.request_id, 1'b0, '0, 1'b1);
          state_d = S_EMIT;
        end
      end

      S_DEL: begin
        if (!in_req_ok || !has_timer_q[ri_q]) begin
          res_d   = mk_res(K_NODEL, cmd_q.request_id, 1'b0, '0, 1'b1);
          state_d = S_EMIT;
        end else begin
          rs_re   = 1'b1; rs_ra = ri_q;
          ht_clr  = 1'b1;
          state_d = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        del_we  = 1'b1; del_wa = rs_rd_q; del_wd = 1'b1;
        res_d   = mk_res(K_DELETED, cmd_q.request_id, 1'b0, '0, 1'b1);
        state_d = S_EMIT;
      end

      S_TOP: begin
        if (cnt_q == '0) begin
          if (cmd_q.mode == M_FIND) begin
            res_d   = mk_res(K_NOTIMER, '0, 1'b0, '0, 1'b1);
            state_d = S_EMIT;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          heap_re = 1'b1; heap_ra = '0;
          state_d = S_TOP_RD;
        end
      end

      S_TOP_RD: begin
        top_d   = heap_rd_q;
        node_re = 1'b1; node_ra = heap_rd_q.slot;
        state_d = S_NODE_CHK;
      end

      S_NODE_CHK: begin
        if (del_rd_q) begin
          state_d = S_POP_RS;
        end else if (cmd_q.mode == M_FIND) begin
          res_d   = mk_res(K_WAIT, node_rd_q.req, 1'b0, wait_v, 1'b1);
          state_d = S_EMIT;
        end else if (top_q.dl > now_t) begin
          state_d = S_FIN;
        end else if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_d     = pend_q;
            out_vld_d = 1'b1;
          end
          pend_d     = mk_res(K_EXPIRED, node_rd_q.req, node_rd_q.hnd, '0, 1'b0);
          pend_vld_d = 1'b1;
          state_d    = S_POP_RS;
        end
      end

      // pop the minimum: unlink its request if still linked, free its slot
      S_POP_RS: begin
        rs_re   = 1'b1; rs_ra = node_ri;
        state_d = S_POP_LINK;
      end

      S_POP_LINK: begin
        ht_idx = node_ri;
        if (node_req_ok && has_timer_q[node_ri] && rs_rd_q == top_q.slot) ht_clr = 1'b1;
        free_d[top_q.slot] = 1'b1;
        heap_re = 1'b1; heap_ra = SW'(cnt_q - CW'(1));
        state_d = S_POP_LAST;
      end

      S_POP_LAST: begin
        key_d   = heap_rd_q;
        cnt_d   = cnt_q - CW'(1);
        pos_d   = PW'(1);
        state_d = S_DN;
      end

      // sift-down with a hole: the smaller child moves up while below the key
      S_DN: begin
        if (two_p > PW'(cnt_q)) begin
          heap_we = 1'b1; heap_wa = SW'(pos_q - PW'(1)); heap_wd = key_q;
          state_d = S_TOP;
        end else begin
          heap_re = 1'b1; heap_ra = SW'(two_p - PW'(1));
          state_d = S_DN_RL;
        end
      end

      S_DN_RL: begin
        left_d = heap_rd_q;
        if (two_p < PW'(cnt_q)) begin
          heap_re = 1'b1; heap_ra = SW'(two_p);
        end
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        heap_we = 1'b1; heap_wa = SW'(pos_q - PW'(1));
        if (child.dl < key_q.dl) begin
          heap_wd = child;
          pos_d   = child_pos;
          state_d = S_DN;
        end else begin
          heap_wd = key_q;
          state_d = S_TOP;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (pend_vld_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
            pend_vld_d = 1'b0;
          end else begin
            out_d = mk_res(K_NONE, '0, 1'b0, '0, 1'b1);
          end
          state_d = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      free_q     <= '1;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < REQUEST_COUNT; i++) has_timer_q[i] <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      free_q     <= free_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (ht_set) has_timer_q[ri_q] <= 1'b1;
      if (ht_clr) has_timer_q[ht_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ri_q   <= ri_d;
    pos_q  <= pos_d;
    key_q  <= key_d;
    top_q  <= top_d;
    left_q <= left_d;
    res_q  <= res_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // ---- RAMs, registered read ----
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) heap_rd_q <= heap_mem[heap_ra];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    if (del_we)  del_mem[del_wa]   <= del_wd;
    if (node_re) begin
      node_rd_q <= node_mem[node_ra];
      del_rd_q  <= del_mem[node_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    if (rs_re) rs_rd_q <= rs_mem[rs_ra];
  end

`ifndef SYNTH
  // every pool slot is either free or held by exactly one heap entry
  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(free_q) + 32'(cnt_q) == POOL_DEPTH))
    else $error("free slots and heap count disagree");

  // no expired result may be left over once a command is finished
  a_pend_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_vld_q)
    else $error("held expired result left at idle");

  // an accepted command always leaves idle on the next cycle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q != S_IDLE))
    else $error("accepted command not started");

  // the heap never grows past the pool
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= POOL_DEPTH)
    else $error("heap count above pool depth");
`endif

endmodule
